>>> sv/ssq_pkg.sv
package ssq_pkg;

  localparam int WAKE_W = 63;
  localparam int TID_W  = 8;
  localparam int STAT_W = 3;

  localparam logic [WAKE_W-1:0] EMPTY_WAKE = {WAKE_W{1'b1}};

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  localparam logic [STAT_W-1:0] ST_WOKEN     = 3'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_SLEPT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE_DUE  = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [TID_W-1:0]  thread_id;
    logic [WAKE_W-1:0] wake_time;
    logic [WAKE_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TID_W-1:0]  woken_id;
    logic              last;
    logic [WAKE_W-1:0] first_wake;
  } res_t;

  typedef struct packed {
    logic insert;  // place key entry behind all entries with wake <= key
    logic shift;   // pop head: every cell takes its right neighbor
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RELEASE
  } state_t;

endpackage

>>> sv/ssq_cell.sv
module ssq_cell
  import ssq_pkg::*;
#(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [WAKE_W-1:0]  key_wake,
  input  logic [ID_BITS-1:0] key_id,
  input  logic               left_valid,
  input  logic [WAKE_W-1:0]  left_wake,
  input  logic [ID_BITS-1:0] left_id,
  input  logic               left_le,
  input  logic               right_valid,
  input  logic [WAKE_W-1:0]  right_wake,
  input  logic [ID_BITS-1:0] right_id,
  output logic               valid,
  output logic [WAKE_W-1:0]  wake,
  output logic [ID_BITS-1:0] id,
  output logic               le,
  output logic               eq
);

  logic               valid_r, valid_nxt;
  logic [WAKE_W-1:0]  wake_r, wake_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;

  assign valid = valid_r;
  assign wake  = wake_r;
  assign id    = id_r;
  assign le    = valid_r && (wake_r <= key_wake);
  assign eq    = valid_r && (wake_r == key_wake);

  always_comb begin
    valid_nxt = valid_r;
    wake_nxt  = wake_r;
    id_nxt    = id_r;
    if (ctrl.shift) begin
      valid_nxt = right_valid;
      wake_nxt  = right_wake;
      id_nxt    = right_id;
    end else if (ctrl.insert && !le) begin
      if (left_le) begin
        // first cell past the insertion point takes the new entry
        valid_nxt = 1'b1;
        wake_nxt  = key_wake;
        id_nxt    = key_id;
      end else begin
        valid_nxt = left_valid;
        wake_nxt  = left_wake;
        id_nxt    = left_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r <= wake_nxt;
    id_r   <= id_nxt;
  end

endmodule

>>> sv/sorted_sleep_timer_queue.sv
// Channel  Ports                    Handshake
// -------  -----------------------  -------------------------------------
// request  start, busy, in_data     taken at clk edge with start & !busy
// result   out_strobe, out_data     one-cycle strobe per result, no back-pressure
//
// Sleep request: accept, then one compare/insert step (S_EVAL) in the cells.
// Tick: accept, then S_EVAL; if an entry is due, S_RELEASE follows with
//   one pop of the cell chain per woken entry.
// Results appear in the cycle after the evaluating cycle, from an output register;
//   a new request may be accepted while the last result is on the ports.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass.
module sorted_sleep_timer_queue
  import ssq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_data,
  output logic out_strobe,
  output res_t out_data
);

  state_t            state_r, state_nxt;
  req_t              req_r;
  res_t              out_data_r, out_data_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [WAKE_W-1:0] rel_r, rel_nxt;   // wake time being released
  logic [WAKE_W-1:0] nw_r, nw_nxt;     // earliest wake after the release

  cell_ctrl_t         ctrl;
  logic [WAKE_W-1:0]  key_wake;
  logic [ID_BITS-1:0] key_id;

  logic               valid_a [QUEUE_DEPTH];
  logic [WAKE_W-1:0]  wake_a  [QUEUE_DEPTH];
  logic [ID_BITS-1:0] id_a    [QUEUE_DEPTH];
  logic               le_a    [QUEUE_DEPTH];
  logic               eq_a    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_v;

  logic [WAKE_W-1:0] head_wake;
  logic [WAKE_W-1:0] bound_wake;
  logic              bound_any;
  logic              due;
  logic              full;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic               l_valid, l_le, r_valid;
      logic [WAKE_W-1:0]  l_wake, r_wake;
      logic [ID_BITS-1:0] l_id, r_id;

      if (gi == 0) begin : g_first
        assign l_valid = 1'b0;
        assign l_wake  = key_wake;
        assign l_id    = key_id;
        assign l_le    = 1'b1;
      end else begin : g_mid
        assign l_valid = valid_a[gi-1];
        assign l_wake  = wake_a[gi-1];
        assign l_id    = id_a[gi-1];
        assign l_le    = le_a[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_wake  = '0;
        assign r_id    = '0;
      end else begin : g_inner
        assign r_valid = valid_a[gi+1];
        assign r_wake  = wake_a[gi+1];
        assign r_id    = id_a[gi+1];
      end

      ssq_cell #(
        .ID_BITS(ID_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .key_wake   (key_wake),
        .key_id     (key_id),
        .left_valid (l_valid),
        .left_wake  (l_wake),
        .left_id    (l_id),
        .left_le    (l_le),
        .right_valid(r_valid),
        .right_wake (r_wake),
        .right_id   (r_id),
        .valid      (valid_a[gi]),
        .wake       (wake_a[gi]),
        .id         (id_a[gi]),
        .le         (le_a[gi]),
        .eq         (eq_a[gi])
      );

      assign valid_v[gi] = valid_a[gi];
    end
  endgenerate

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign head_wake = valid_a[0] ? wake_a[0] : EMPTY_WAKE;
  assign due       = valid_a[0] && (req_r.now == wake_a[0]);
  assign full      = valid_a[QUEUE_DEPTH-1];

  // Entries equal to the head form a prefix; pick the first one past it.
  always_comb begin
    bound_wake = '0;
    bound_any  = 1'b0;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      if (valid_a[i] && !eq_a[i] && eq_a[i-1]) begin
        bound_wake = bound_wake | wake_a[i];
        bound_any  = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (req_r.opcode == OP_TICK && due) begin
          state_nxt = S_RELEASE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RELEASE: begin
        if (!eq_a[1]) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl           = '0;
    key_wake       = req_r.wake_time;
    key_id         = ID_BITS'(req_r.thread_id);
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    rel_nxt        = rel_r;
    nw_nxt         = nw_r;
    case (state_r)
      S_EVAL: begin
        if (req_r.opcode == OP_SLEEP) begin
          out_strobe_nxt          = 1'b1;
          out_data_nxt.woken_id   = '0;
          out_data_nxt.last       = 1'b1;
          out_data_nxt.first_wake = head_wake;
          if (req_r.now >= req_r.wake_time) begin
            out_data_nxt.status = ST_NOT_SLEPT;
          end else if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            ctrl.insert             = 1'b1;
            out_data_nxt.status     = ST_QUEUED;
            out_data_nxt.first_wake = le_a[0] ? wake_a[0] : req_r.wake_time;
          end
        end else begin
          key_wake = wake_a[0];
          if (due) begin
            rel_nxt = wake_a[0];
            nw_nxt  = bound_any ? bound_wake : EMPTY_WAKE;
          end else begin
            out_strobe_nxt          = 1'b1;
            out_data_nxt.status     = ST_NONE_DUE;
            out_data_nxt.woken_id   = '0;
            out_data_nxt.last       = 1'b1;
            out_data_nxt.first_wake = head_wake;
          end
        end
      end
      S_RELEASE: begin
        key_wake                = rel_r;
        ctrl.shift              = 1'b1;
        out_strobe_nxt          = 1'b1;
        out_data_nxt.status     = ST_WOKEN;
        out_data_nxt.woken_id   = TID_W'(id_a[0]);
        out_data_nxt.last       = !eq_a[1];
        out_data_nxt.first_wake = nw_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    rel_r      <= rel_nxt;
    nw_r       <= nw_nxt;
  end

`ifndef SYNTHESIS
  // occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_v & (valid_v + QUEUE_DEPTH'(1))) == '0)
    else $error("occupied cells not contiguous");

  // a release that is not the last one is followed by another release
  a_release_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_data_r.last |=> out_strobe_r && out_data_r.status == ST_WOKEN)
    else $error("release run broken");

  // the cycle after a request is taken carries no result
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe_r)
    else $error("result right after accept");

  // non-final results only come while the block is still busy
  a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_data_r.last |-> busy)
    else $error("pending release while idle");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top
  import ssq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 32;
  localparam logic [WAKE_W-1:0] MAX_TICK = EMPTY_WAKE - 1'b1;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_data;
  logic out_strobe;
  res_t out_data;

  sorted_sleep_timer_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_BITS(TID_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the sleep queue
  logic [WAKE_W-1:0] shadow_wake [QDEPTH];
  logic [TID_W-1:0]  shadow_tid  [QDEPTH];
  int                shadow_count;
  logic [WAKE_W-1:0] shadow_earliest;

  res_t pending_results[$];
  res_t head_res;

  int mismatches = 0;
  int stray_results = 0;
  bit no_gaps = 1'b0;

  int sleeps_sent = 0;
  int ticks_sent = 0;
  int threads_woken = 0;
  int full_rejects = 0;
  int widest_release = 0;

  // Applies one accepted request to the shadow queue and queues its results.
  function automatic void predict_timer_step(input req_t r);
    logic [TID_W-1:0] woken_ids[$];
    res_t one;
    int pos;
    int n;
    one = '0;
    one.last = 1'b1;
    n = 0;
    if (r.opcode == OP_SLEEP) begin
      sleeps_sent++;
      if (r.now >= r.wake_time) begin
        one.status = ST_NOT_SLEPT;
      end else if (shadow_count >= QDEPTH) begin
        one.status = ST_FULL;
        full_rejects++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_wake[pos] <= r.wake_time) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_wake[i] = shadow_wake[i-1];
          shadow_tid[i]  = shadow_tid[i-1];
        end
        shadow_wake[pos] = r.wake_time;
        shadow_tid[pos]  = r.thread_id;
        shadow_count++;
        one.status = ST_QUEUED;
      end
    end else begin
      ticks_sent++;
      if (shadow_count > 0 && r.now == shadow_earliest) begin
        while (n < shadow_count && shadow_wake[n] <= shadow_earliest) begin
          woken_ids.push_back(shadow_tid[n]);
          n++;
        end
        for (int i = n; i < shadow_count; i++) begin
          shadow_wake[i-n] = shadow_wake[i];
          shadow_tid[i-n]  = shadow_tid[i];
        end
        shadow_count -= n;
      end
      if (n == 0) one.status = ST_NONE_DUE;
    end
    shadow_earliest = (shadow_count > 0) ? shadow_wake[0] : EMPTY_WAKE;
    if (n == 0) begin
      one.first_wake = shadow_earliest;
      pending_results.push_back(one);
    end else begin
      threads_woken += n;
      if (n > widest_release) widest_release = n;
      for (int k = 0; k < n; k++) begin
        one = '0;
        one.status     = ST_WOKEN;
        one.woken_id   = woken_ids[k];
        one.last       = (k == n - 1);
        one.first_wake = shadow_earliest;
        pending_results.push_back(one);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [WAKE_W-1:0] rand_wake();
    return WAKE_W'({$urandom, $urandom});
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_req(input logic op, input logic [TID_W-1:0] tid,
                          input logic [WAKE_W-1:0] wake, input logic [WAKE_W-1:0] now_t);
    req_t r;
    int gap;
    r.opcode    = op;
    r.thread_id = tid;
    r.wake_time = wake;
    r.now       = now_t;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_step(r);
  endtask

  task automatic sleep_req(input logic [TID_W-1:0] tid, input logic [WAKE_W-1:0] wake,
                           input logic [WAKE_W-1:0] now_t);
    send_req(OP_SLEEP, tid, wake, now_t);
  endtask

  task automatic tick_req(input logic [WAKE_W-1:0] now_t);
    send_req(OP_TICK, TID_W'($urandom), rand_wake(), now_t);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= 10)
          $display("%0t: unexpected result status=%0d id=%0d last=%0b next=%h",
                   $realtime, out_data.status, out_data.woken_id, out_data.last,
                   out_data.first_wake);
      end else begin
        head_res = pending_results.pop_front();
        if (out_data.status !== head_res.status || out_data.woken_id !== head_res.woken_id ||
            out_data.last !== head_res.last || out_data.first_wake !== head_res.first_wake) begin
          mismatches++;
          if (mismatches + stray_results <= 10)
            $display("%0t: mismatch exp status=%0d id=%0d last=%0b next=%h / got %0d %0d %0b %h",
                     $realtime, head_res.status, head_res.woken_id, head_res.last,
                     head_res.first_wake, out_data.status, out_data.woken_id, out_data.last,
                     out_data.first_wake);
        end
      end
    end
  end

  task automatic test_empty_tick();
    tick_req('0);
    tick_req(MAX_TICK);
  endtask

  // extremes of ids and times, not-slept boundary, ties in arrival order
  task automatic test_sleep_basic();
    sleep_req(8'hFF, 63'd10, 63'd3);
    sleep_req(8'h00, 63'd10, 63'd0);
    sleep_req(8'h01, 63'd7, 63'd0);
    sleep_req(8'h02, 63'd0, 63'd0);
    sleep_req(8'h03, 63'd5, MAX_TICK);
    sleep_req(8'h04, 63'd9, 63'd9);
    sleep_req(8'h05, MAX_TICK, 63'd0);
    tick_req(63'd6);
    tick_req(63'd7);
    tick_req(63'd10);
    tick_req(MAX_TICK);
  endtask

  // an all-ones wake time is a real entry, even though it reads like empty
  task automatic test_sentinel_wake();
    sleep_req(8'hA5, EMPTY_WAKE, 63'd1);
    tick_req(63'd5);
    tick_req(EMPTY_WAKE);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH; i++) sleep_req(TID_W'(i * 7 + 3), 63'd100, 63'd20);
    sleep_req(8'h5A, 63'd50, 63'd20);
    sleep_req(8'h5B, 63'd20, 63'd20);
    tick_req(63'd99);
    tick_req(63'd100);
  endtask

  task automatic test_random_traffic(input int count);
    logic [WAKE_W-1:0] cur;
    int sel;
    cur = ($urandom_range(0, 1) != 0) ? rand_wake() >> 1 : WAKE_W'($urandom_range(0, 1000));
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == count / 3 || i == 2 * count / 3) begin
        wait_for_drain();
        // fill up from the current level, then push past full
        while (shadow_count < QDEPTH) begin
          sleep_req(TID_W'($urandom), cur + $urandom_range(1, 6), cur);
          i++;
        end
        sleep_req(TID_W'($urandom), cur + 2, cur);
        i++;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_req(1'($urandom), TID_W'($urandom), rand_wake(), rand_wake());
      end else if (sel < 50 || (shadow_count == 0 && sel < 75)) begin
        if (sel < 12)
          sleep_req(TID_W'($urandom), cur - $urandom_range(0, 3), cur);
        else
          sleep_req(TID_W'($urandom), cur + $urandom_range(0, 10), cur);
      end else if (sel < 88) begin
        if (shadow_count > 0) cur = shadow_earliest;
        tick_req(cur);
      end else begin
        cur = cur + $urandom_range(0, 2);
        tick_req(cur);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    shadow_count    = 0;
    shadow_earliest = EMPTY_WAKE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_tick();
    test_sleep_basic();
    wait_for_drain();
    test_sentinel_wake();
    test_full_queue();
    wait_for_drain();
    test_random_traffic(230);

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d sleep and %0d tick requests: %0d threads woken, %0d full rejects,",
             sleeps_sent, ticks_sent, threads_woken, full_rejects);
    $display("largest single release %0d entries; %0d mismatches, %0d unexpected results.",
             widest_release, mismatches, stray_results);
    if (mismatches == 0 && stray_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
sv/ssq_pkg.sv
sv/ssq_cell.sv
sv/sorted_sleep_timer_queue.sv
tb/sv/tb_top.sv
